### rtl/core/s2a_pkg.sv
// shared types, constants and tables for the spherical-to-joint-goal pipeline
package s2a_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    localparam int LATENCY = 3 * CORDIC_N + 11;

    localparam int W   = 36;
    localparam int QW  = 16;
    localparam int DW  = 50;
    localparam int PW  = 64;

    typedef logic signed [W-1:0]  t_word;
    typedef logic signed [QW-1:0] t_quo;
    typedef logic signed [DW-1:0] t_dvd;
    typedef logic signed [PW-1:0] t_prod;

    localparam t_word ANG_PI      = 36'sd3373259426;
    localparam t_word ANG_HALF_PI = 36'sd1686629713;
    localparam t_word GAIN_INIT   = 36'sd652032874;
    localparam logic signed [30:0] GAIN_MUL = 31'sd652032874;

    localparam int DIV_SHIFT = 48;
    localparam logic signed [29:0] DIV_RECIP =
        30'(((64'd1 << (DIV_SHIFT + 11)) / 64'd3373259426));
    localparam logic signed [33:0] DIV_PI = 34'sd3373259426;

    localparam t_word ATAN_TAB [TABLE_LEN] = '{
        36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
        36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
        36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
        36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
        36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
        36'sd1023,      36'sd511,       36'sd255,       36'sd127
    };

    typedef enum logic {
        CFG_ROLL_OFFSET = 1'b0,
        CFG_ELBOW_GOAL  = 1'b1
    } t_cfg_idx;

    localparam logic [11:0] ROLL_OFFSET_RST = 12'd2600;
    localparam logic [11:0] ELBOW_GOAL_RST  = 12'd1024;

    typedef struct packed {
        t_word x;
        logic  zero;
        logic  rej;
    } t_xside;

    typedef struct packed {
        t_word ang;
        logic  rej;
    } t_pside;

endpackage

### rtl/core/spherical_to_arm_joint_goals.sv
// top level: direction angles in, shoulder roll, shoulder pitch and elbow goals out
//
// a request is taken at a rising edge with start high and busy low; the tilt
// and heading angle fields are signed q3.13 radians. busy is high only
// while reset is held and in the cycle after it, then stays low: a new
// request may be given in every cycle.
// every request gives exactly one result, shown for one cycle with o_valid
// high. the pipeline depth is set by three cordic pipelines in series
// (sine/cosine, pitch vectoring, roll vectoring) of 16 cordic stages each,
// two multiplier stages and a three-stage division by pi.
// a direction with non-negative x gives o_accepted low and all goals zero.
// the receiver cannot stall; results leave in request order.
// reset empties the pipeline, dropping requests in flight, and sets
// roll_offset to 2600 and elbow_goal to 1024. the config port writes one
// register per edge with i_cfg_we high; write it only while no request is in
// flight.
module spherical_to_arm_joint_goals (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_tilt_ang,
    input  logic signed [15:0] i_heading_ang,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [11:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_accepted,
    output logic [11:0]        o_roll_goal,
    output logic [11:0]        o_pitch_goal,
    output logic [11:0]        o_elbow_position
);
    localparam int N = s2a_pkg::CORDIC_N;

    logic               r_rdy;
    logic [11:0]        r_roll_off;
    logic [11:0]        r_elbow;
    logic               in_vld;
    s2a_pkg::t_word     polar_w;
    s2a_pkg::t_word     azim_w;

    logic               sc_p_vld;
    s2a_pkg::t_word     sin_p;
    s2a_pkg::t_word     cos_p;
    logic               sc_a_vld;
    s2a_pkg::t_word     sin_a;
    s2a_pkg::t_word     cos_a;
    logic signed [31:0] sp32;
    logic signed [31:0] sa32;
    logic signed [31:0] ca32;

    logic               r_p_vld;
    s2a_pkg::t_prod     r_xp;
    s2a_pkg::t_prod     r_yp;
    s2a_pkg::t_word     r_z;
    s2a_pkg::t_word     x_w;
    s2a_pkg::t_word     y_w;
    s2a_pkg::t_xside    n_xs;

    s2a_pkg::t_xside    r_xd [N+3];
    s2a_pkg::t_pside    r_pd [N+2];
    logic               r_rj [3];

    logic               pv_vld;
    s2a_pkg::t_word     pv_ang;
    s2a_pkg::t_word     pv_len;
    logic signed [32:0] len33;

    logic               r_m_vld;
    s2a_pkg::t_prod     r_mprod;
    s2a_pkg::t_word     r_pang;
    s2a_pkg::t_word     mag_w;

    logic               rv_vld;
    s2a_pkg::t_word     rv_ang;
    s2a_pkg::t_word     rv_len;

    logic               qr_vld;
    s2a_pkg::t_quo      qr_q;
    logic               qr_exact;
    logic               qp_vld;
    s2a_pkg::t_quo      qp_q;
    logic               qp_exact;

    logic signed [16:0] n_roll_t;
    s2a_pkg::t_quo      n_pitch_q;

    logic               r_valid;
    logic               r_acc;
    logic [11:0]        r_roll;
    logic [11:0]        r_pitch;
    logic [11:0]        r_elb_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy   = !r_rdy;
    assign in_vld = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_off <= s2a_pkg::ROLL_OFFSET_RST;
            r_elbow    <= s2a_pkg::ELBOW_GOAL_RST;
        end else if (i_cfg_we) begin
            unique case (s2a_pkg::t_cfg_idx'(i_cfg_idx))
                s2a_pkg::CFG_ROLL_OFFSET: r_roll_off <= i_cfg_data;
                s2a_pkg::CFG_ELBOW_GOAL:  r_elbow    <= i_cfg_data;
            endcase
        end
    end

    // q3.13 to 2^-30 units
    assign polar_w = s2a_pkg::W'(i_tilt_ang) <<< 17;
    assign azim_w  = s2a_pkg::W'(i_heading_ang) <<< 17;

    s2a_sincos u_sc_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (in_vld),
        .i_ang   (polar_w),
        .o_vld   (sc_p_vld),
        .o_sin   (sin_p),
        .o_cos   (cos_p)
    );

    s2a_sincos u_sc_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (in_vld),
        .i_ang   (azim_w),
        .o_vld   (sc_a_vld),
        .o_sin   (sin_a),
        .o_cos   (cos_a)
    );

    assign sp32 = sin_p[31:0];
    assign sa32 = sin_a[31:0];
    assign ca32 = cos_a[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= sc_p_vld && sc_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xp <= s2a_pkg::PW'(sp32 * ca32);
        r_yp <= s2a_pkg::PW'(sp32 * sa32);
        r_z  <= cos_p;
    end

    assign x_w       = s2a_pkg::W'(r_xp >>> 30);
    assign y_w       = s2a_pkg::W'(r_yp >>> 30);
    assign n_xs.x    = x_w;
    assign n_xs.zero = (y_w == '0) && (r_z == '0);
    assign n_xs.rej  = !x_w[s2a_pkg::W-1];

    s2a_vec u_vec_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p_vld),
        .i_u     (r_z),
        .i_v     (-y_w),
        .o_vld   (pv_vld),
        .o_ang   (pv_ang),
        .o_len   (pv_len)
    );

    always_ff @(posedge i_clk) begin
        r_xd[0] <= n_xs;
        for (int k = 1; k < N + 3; k++) begin
            r_xd[k] <= r_xd[k-1];
        end
    end

    assign len33 = pv_len[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= pv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mprod <= s2a_pkg::PW'(len33 * s2a_pkg::GAIN_MUL);
        r_pang  <= r_xd[N+1].zero ? '0 : pv_ang;
    end

    assign mag_w = r_xd[N+2].zero ? '0 : s2a_pkg::W'(r_mprod >>> 30);

    s2a_vec u_vec_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m_vld),
        .i_u     (-r_xd[N+2].x),
        .i_v     (mag_w),
        .o_vld   (rv_vld),
        .o_ang   (rv_ang),
        .o_len   (rv_len)
    );

    always_ff @(posedge i_clk) begin
        r_pd[0].ang <= r_pang;
        r_pd[0].rej <= r_xd[N+2].rej;
        for (int k = 1; k < N + 2; k++) begin
            r_pd[k] <= r_pd[k-1];
        end
    end

    s2a_qdiv u_div_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rv_vld),
        .i_ang   (rv_ang),
        .o_vld   (qr_vld),
        .o_q     (qr_q),
        .o_exact (qr_exact)
    );

    s2a_qdiv u_div_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rv_vld),
        .i_ang   (r_pd[N+1].ang),
        .o_vld   (qp_vld),
        .o_q     (qp_q),
        .o_exact (qp_exact)
    );

    always_ff @(posedge i_clk) begin
        r_rj[0] <= r_pd[N+1].rej;
        r_rj[1] <= r_rj[0];
        r_rj[2] <= r_rj[1];
    end

    // truncate toward zero from the floor quotient
    always_comb begin
        n_roll_t  = $signed({5'b0, r_roll_off}) - 17'(qr_q);
        n_pitch_q = qp_q;
        if (!qr_exact && (n_roll_t > 17'sd0)) begin
            n_roll_t = n_roll_t - 17'sd1;
        end
        if (!qp_exact && qp_q[s2a_pkg::QW-1]) begin
            n_pitch_q = qp_q + 16'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= qr_vld && qp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= !r_rj[2];
        r_roll    <= r_rj[2] ? 12'd0 : n_roll_t[11:0];
        r_pitch   <= r_rj[2] ? 12'd0 : n_pitch_q[11:0];
        r_elb_out <= r_rj[2] ? 12'd0 : r_elbow;
    end

    assign o_valid          = r_valid;
    assign o_accepted       = r_acc;
    assign o_roll_goal      = r_roll;
    assign o_pitch_goal     = r_pitch;
    assign o_elbow_position = r_elb_out;

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |->
            (o_roll_goal == 12'd0 && o_pitch_goal == 12'd0 && o_elbow_position == 12'd0))
        else $error("rejected direction with nonzero goals");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, s2a_pkg::LATENCY + 1))
        else $error("result without a matching request");

    a_vld_align : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qr_vld == qp_vld) && (sc_p_vld == sc_a_vld))
        else $error("parallel pipelines out of step");

endmodule

### rtl/core/s2a_sincos.sv
// pipelined rotation-mode cordic giving sine and cosine of one angle
module s2a_sincos (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  s2a_pkg::t_word i_ang,
    output logic           o_vld,
    output s2a_pkg::t_word o_sin,
    output s2a_pkg::t_word o_cos
);
    localparam int N = s2a_pkg::CORDIC_N;

    logic           r_vld [N+1];
    s2a_pkg::t_word r_x   [N+1];
    s2a_pkg::t_word r_y   [N+1];
    s2a_pkg::t_word r_z   [N+1];
    logic           r_neg [N+1];

    s2a_pkg::t_word n_z;
    logic           n_neg;
    logic           r_ovld;
    s2a_pkg::t_word r_sin;
    s2a_pkg::t_word r_cos;

    // range reduction into [-pi/2, pi/2]
    always_comb begin
        n_z   = i_ang;
        n_neg = 1'b0;
        if (i_ang > s2a_pkg::ANG_HALF_PI) begin
            n_z   = i_ang - s2a_pkg::ANG_PI;
            n_neg = 1'b1;
        end else if (i_ang < -s2a_pkg::ANG_HALF_PI) begin
            n_z   = i_ang + s2a_pkg::ANG_PI;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= s2a_pkg::GAIN_INIT;
        r_y[0]   <= '0;
        r_z[0]   <= n_z;
        r_neg[0] <= n_neg;
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[k] <= r_neg[k-1];
            if (!r_z[k-1][s2a_pkg::W-1]) begin
                r_x[k] <= r_x[k-1] - (r_y[k-1] >>> (k-1));
                r_y[k] <= r_y[k-1] + (r_x[k-1] >>> (k-1));
                r_z[k] <= r_z[k-1] - s2a_pkg::ATAN_TAB[k-1];
            end else begin
                r_x[k] <= r_x[k-1] + (r_y[k-1] >>> (k-1));
                r_y[k] <= r_y[k-1] - (r_x[k-1] >>> (k-1));
                r_z[k] <= r_z[k-1] + s2a_pkg::ATAN_TAB[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sin <= r_neg[N] ? -r_y[N] : r_y[N];
        r_cos <= r_neg[N] ? -r_x[N] : r_x[N];
    end

    assign o_vld = r_ovld;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### rtl/core/s2a_vec.sv
// pipelined vectoring-mode cordic giving angle and raw length of a vector
module s2a_vec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  s2a_pkg::t_word i_u,
    input  s2a_pkg::t_word i_v,
    output logic           o_vld,
    output s2a_pkg::t_word o_ang,
    output s2a_pkg::t_word o_len
);
    localparam int N = s2a_pkg::CORDIC_N;

    logic           r_vld [N+1];
    s2a_pkg::t_word r_u   [N+1];
    s2a_pkg::t_word r_v   [N+1];
    s2a_pkg::t_word r_z   [N+1];
    s2a_pkg::t_word r_off [N+1];

    s2a_pkg::t_word n_u;
    s2a_pkg::t_word n_v;
    s2a_pkg::t_word n_off;
    logic           r_ovld;
    s2a_pkg::t_word r_ang;
    s2a_pkg::t_word r_len;

    // left half plane: flip the vector and add or subtract pi
    always_comb begin
        n_u   = i_u;
        n_v   = i_v;
        n_off = '0;
        if (i_u[s2a_pkg::W-1]) begin
            n_u   = -i_u;
            n_v   = -i_v;
            n_off = i_v[s2a_pkg::W-1] ? -s2a_pkg::ANG_PI : s2a_pkg::ANG_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u[0]   <= n_u;
        r_v[0]   <= n_v;
        r_z[0]   <= '0;
        r_off[0] <= n_off;
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_off[k] <= r_off[k-1];
            if (!r_v[k-1][s2a_pkg::W-1]) begin
                r_u[k] <= r_u[k-1] + (r_v[k-1] >>> (k-1));
                r_v[k] <= r_v[k-1] - (r_u[k-1] >>> (k-1));
                r_z[k] <= r_z[k-1] + s2a_pkg::ATAN_TAB[k-1];
            end else begin
                r_u[k] <= r_u[k-1] - (r_v[k-1] >>> (k-1));
                r_v[k] <= r_v[k-1] + (r_u[k-1] >>> (k-1));
                r_z[k] <= r_z[k-1] - s2a_pkg::ATAN_TAB[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= r_z[N] + r_off[N];
        r_len <= r_u[N];
    end

    assign o_vld = r_ovld;
    assign o_ang = r_ang;
    assign o_len = r_len;

endmodule

### rtl/core/s2a_qdiv.sv
// three-stage floor division of angle*2048 by pi with an exactness flag
module s2a_qdiv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  s2a_pkg::t_word i_ang,
    output logic           o_vld,
    output s2a_pkg::t_quo  o_q,
    output logic           o_exact
);
    logic                 r_vld1;
    logic                 r_vld2;
    logic                 r_vld3;
    s2a_pkg::t_prod       r_prod;
    s2a_pkg::t_dvd        r_d1;
    s2a_pkg::t_dvd        r_d2;
    s2a_pkg::t_quo        r_qest;
    s2a_pkg::t_dvd        r_qp;
    s2a_pkg::t_quo        r_q;
    logic                 r_exact;

    logic signed [33:0]   ang_s;
    s2a_pkg::t_quo        qest;
    s2a_pkg::t_dvd        n_rem;
    s2a_pkg::t_quo        n_q;
    logic                 n_exact;

    assign ang_s = i_ang[33:0];
    assign qest  = r_prod[s2a_pkg::DIV_SHIFT +: s2a_pkg::QW];

    // estimate is off by at most one either way
    always_comb begin
        n_rem   = r_d2 - r_qp;
        n_q     = r_qest;
        n_exact = (n_rem == '0);
        if (n_rem[s2a_pkg::DW-1]) begin
            n_q     = r_qest - 16'sd1;
            n_exact = (n_rem == -s2a_pkg::DW'(s2a_pkg::DIV_PI));
        end else if (n_rem >= s2a_pkg::DW'(s2a_pkg::DIV_PI)) begin
            n_q     = r_qest + 16'sd1;
            n_exact = (n_rem == s2a_pkg::DW'(s2a_pkg::DIV_PI));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= s2a_pkg::PW'(ang_s * s2a_pkg::DIV_RECIP);
        r_d1    <= s2a_pkg::DW'(i_ang) <<< 11;
        r_qest  <= qest;
        r_qp    <= s2a_pkg::DW'(qest * s2a_pkg::DIV_PI);
        r_d2    <= r_d1;
        r_q     <= n_q;
        r_exact <= n_exact;
    end

    assign o_vld   = r_vld3;
    assign o_q     = r_q;
    assign o_exact = r_exact;

endmodule
